// ===== design/ps2md_pkg.sv =====
// Shared types, codes and helpers for the PS/2 mouse packet decoder.
package ps2md_pkg;

  localparam int MAX_EV = 7;
  localparam int CNT_W  = 3;
  localparam int ADDR_W = 3;
  localparam int TDATA_W = 48;

  typedef enum logic [1:0] {
    EV_BUTTON  = 2'd0,
    EV_MOVE    = 2'd1,
    EV_SCROLL  = 2'd2,
    EV_COMMAND = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    MK_UNKNOWN = 2'd0,
    MK_PLAIN   = 2'd1,
    MK_WHEEL   = 2'd2,
    MK_FIVE    = 2'd3
  } mouse_kind_t;

  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_IDENTIFY = 8'hF2;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;

  localparam logic [7:0] KNOCK_RATE_HI  = 8'd200;
  localparam logic [7:0] KNOCK_RATE_STD = 8'd100;
  localparam logic [7:0] KNOCK_RATE_LO  = 8'd80;

  localparam logic [7:0] ID_WHEEL = 8'h03;
  localparam logic [7:0] ID_FIVE  = 8'h04;

  localparam logic [7:0] RUN_RATE_RESET = 8'd100;

  localparam logic REG_RUN_RATE = 1'b0;

  typedef struct packed {
    ev_kind_t           kind;
    logic [2:0]         button_index;
    logic               pressed;
    logic signed [8:0]  move_x;
    logic signed [8:0]  move_y;
    logic signed [3:0]  wheel;
    logic [7:0]         device_command;
    logic [7:0]         command_argument;
    logic               has_argument;
  } ev_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] cnt;
  } ev_ctrl_t;

  function automatic ev_t cmd_ev(logic [7:0] c, logic has, logic [7:0] arg);
    ev_t e;
    e                  = '0;
    e.kind             = EV_COMMAND;
    e.device_command   = c;
    e.has_argument     = has;
    e.command_argument = has ? arg : 8'd0;
    return e;
  endfunction

endpackage

// ===== design/ps2md_decode.sv =====
// Mouse state registers and single-pass decode of one beat into an event list.
module ps2md_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 consume_i,
  input  logic                 cmd_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           run_rate_i,
  output ps2md_pkg::ev_ctrl_t  ctrl_o,
  output ps2md_pkg::ev_t       list_o [ps2md_pkg::MAX_EV]
);
  import ps2md_pkg::*;

  logic             scan_r,  scan_nxt;
  mouse_kind_t      kind_r,  kind_nxt;
  logic [4:0]       held_r,  held_nxt;
  logic [2:0]       bh_r,    bh_nxt;
  logic [7:0]       pkt_r   [4];
  logic [7:0]       pkt_nxt [4];
  logic             pkt_we;

  logic             do_knock;
  logic [7:0]       knock2;
  logic             do_enable;
  logic [1:0]       idx;
  logic [2:0]       fill;
  logic [2:0]       size;
  logic [7:0]       b3;
  logic [4:0]       buttons;
  logic [8:0]       mx;
  logic [8:0]       my;
  logic [3:0]       wh;
  logic [CNT_W-1:0] n;

  always_comb begin
    scan_nxt  = scan_r;
    kind_nxt  = kind_r;
    held_nxt  = held_r;
    bh_nxt    = bh_r;
    pkt_nxt   = pkt_r;
    pkt_we    = 1'b0;
    do_knock  = 1'b0;
    knock2    = KNOCK_RATE_STD;
    do_enable = 1'b0;
    idx       = (bh_r >= 3'd4) ? 2'd0 : bh_r[1:0];
    fill      = {1'b0, idx} + 3'd1;
    size      = (kind_r == MK_PLAIN) ? 3'd3 : 3'd4;
    b3        = 8'd0;
    buttons   = 5'd0;
    mx        = 9'd0;
    my        = 9'd0;
    wh        = 4'd0;
    n         = '0;
    for (int k = 0; k < MAX_EV; k++) begin
      list_o[k] = '0;
    end

    if (!cmd_i) begin
      scan_nxt = 1'b0;
      kind_nxt = MK_UNKNOWN;
      held_nxt = 5'd0;
      bh_nxt   = 3'd0;
      do_knock = 1'b1;
    end else if (!scan_r) begin
      bh_nxt = 3'd0;
      if (byte_i == ID_WHEEL) begin
        if (kind_r == MK_WHEEL) begin
          scan_nxt  = 1'b1;
          do_enable = 1'b1;
        end else begin
          kind_nxt = MK_WHEEL;
          do_knock = 1'b1;
          knock2   = KNOCK_RATE_HI;
        end
      end else if (byte_i == ID_FIVE) begin
        kind_nxt  = MK_FIVE;
        scan_nxt  = 1'b1;
        do_enable = 1'b1;
      end else begin
        kind_nxt  = MK_PLAIN;
        scan_nxt  = 1'b1;
        do_enable = 1'b1;
      end
    end else begin
      pkt_we       = 1'b1;
      pkt_nxt[idx] = byte_i;
      if (!pkt_nxt[0][3]) begin
        bh_nxt = 3'd0;
      end else if (fill != size) begin
        bh_nxt = fill;
      end else begin
        bh_nxt = 3'd0;
        b3     = (size == 3'd4) ? pkt_nxt[3] : 8'd0;
        if (!(kind_r == MK_FIVE && b3[7:6] != 2'b00)) begin
          buttons = {2'b00, pkt_nxt[0][2:0]};
          if (kind_r == MK_FIVE) begin
            buttons[4:3] = b3[5:4];
          end
          mx = {pkt_nxt[0][4], pkt_nxt[1]};
          my = {pkt_nxt[0][5], pkt_nxt[2]};
          wh = (kind_r == MK_WHEEL || kind_r == MK_FIVE) ? b3[3:0] : 4'd0;
          for (int i = 0; i < 5; i++) begin
            if (buttons[i] != held_r[i]) begin
              list_o[n]              = '0;
              list_o[n].kind         = EV_BUTTON;
              list_o[n].button_index = 3'(i);
              list_o[n].pressed      = buttons[i];
              n                      = n + 1'b1;
            end
          end
          held_nxt = buttons;
          if (mx != 9'd0 || my != 9'd0) begin
            list_o[n]        = '0;
            list_o[n].kind   = EV_MOVE;
            list_o[n].move_x = mx;
            list_o[n].move_y = my;
            n                = n + 1'b1;
          end
          if (wh != 4'd0) begin
            list_o[n]       = '0;
            list_o[n].kind  = EV_SCROLL;
            list_o[n].wheel = wh;
            n               = n + 1'b1;
          end
        end
      end
    end

    if (do_knock) begin
      list_o[0] = cmd_ev(CMD_SET_RATE, 1'b1, KNOCK_RATE_HI);
      list_o[1] = cmd_ev(CMD_SET_RATE, 1'b1, knock2);
      list_o[2] = cmd_ev(CMD_SET_RATE, 1'b1, KNOCK_RATE_LO);
      list_o[3] = cmd_ev(CMD_IDENTIFY, 1'b0, 8'd0);
      n         = CNT_W'(4);
    end
    if (do_enable) begin
      list_o[0] = cmd_ev(CMD_SET_RATE, 1'b1, run_rate_i);
      list_o[1] = cmd_ev(CMD_ENABLE, 1'b0, 8'd0);
      n         = CNT_W'(2);
    end

    ctrl_o.load = consume_i;
    ctrl_o.cnt  = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
      kind_r <= MK_UNKNOWN;
      held_r <= 5'd0;
      bh_r   <= 3'd0;
    end else if (consume_i) begin
      scan_r <= scan_nxt;
      kind_r <= kind_nxt;
      held_r <= held_nxt;
      bh_r   <= bh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume_i && pkt_we) begin
      pkt_r <= pkt_nxt;
    end
  end

endmodule

// ===== design/ps2md_drain.sv =====
// Event list buffer and output register that hands out one event per beat.
module ps2md_drain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ps2md_pkg::ev_ctrl_t  ctrl_i,
  input  ps2md_pkg::ev_t       list_i [ps2md_pkg::MAX_EV],
  output logic                 list_free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ps2md_pkg::ev_t       out_ev_o,
  output logic                 out_last_o
);
  import ps2md_pkg::*;

  ev_t              list_r [MAX_EV];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] pos_r;
  logic             list_v_r;
  logic             out_v_r;
  ev_t              out_ev_r;
  logic             out_last_r;
  logic             take;
  logic             at_end;
  logic             fill;

  assign take        = list_v_r && (!out_v_r || out_ready_i);
  assign at_end      = (pos_r == cnt_r - 1'b1);
  assign list_free_o = !list_v_r || (take && at_end);
  assign fill        = ctrl_i.load && (ctrl_i.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_v_r <= 1'b0;
      pos_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (fill) begin
        list_v_r <= 1'b1;
        pos_r    <= '0;
      end else if (take && at_end) begin
        list_v_r <= 1'b0;
      end else if (take) begin
        pos_r <= pos_r + 1'b1;
      end
      if (take) begin
        out_v_r <= 1'b1;
      end else if (out_ready_i) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      list_r <= list_i;
      cnt_r  <= ctrl_i.cnt;
    end
    if (take) begin
      out_ev_r   <= list_r[pos_r];
      out_last_r <= at_end;
    end
  end

  assign out_valid_o = out_v_r;
  assign out_ev_o    = out_ev_r;
  assign out_last_o  = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.load |-> list_free_o)
    else $error("event list overwritten before drained");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    list_v_r |-> (cnt_r != '0 && pos_r < cnt_r))
    else $error("drain position outside event list");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.load |-> ctrl_i.cnt <= CNT_W'(MAX_EV))
    else $error("event count exceeds list depth");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (take && at_end && !fill) |=> !list_v_r)
    else $error("list still marked full after final event");

endmodule

// ===== design/ps2_mouse_packet_decoder_top.sv =====
// Top level of the PS/2 mouse packet decoder: input stage, register port, decode, drain.
//
//  channel | ports                         | beat
//  --------+-------------------------------+----------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | one mouse byte or start request
//  out     | out_tvalid/out_tready/out_tdata| one event or command to the mouse
//  cfg     | psel/penable/pwrite/paddr     | run sample rate write or read
//
//  An input beat is decoded once the event list has drained its previous events;
//  the event list drains one event per cycle through the output register
//  while out_tready is high.
//  Reset is synchronous, active low, and returns the decoder to its power-up state.
//  A stalled output holds its beat; the input stage keeps accepting while the list has room.
module ps2_mouse_packet_decoder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] button_index, [3] pressed, [12:4] move_x, [21:13] move_y, [25:22] wheel,
  // [33:26] device_command, [41:34] command_argument, [42] has_argument
  output logic [ps2md_pkg::TDATA_W-1:0]    out_tdata,
  output logic [1:0]                       out_tuser,  // [1:0] kind
  output logic                             out_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ps2md_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ps2md_pkg::*;

  logic       in_v_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;
  logic [7:0] run_rate_r;
  logic       consume;
  logic       list_free;
  ev_ctrl_t   ctrl;
  ev_t        list [MAX_EV];
  ev_t        out_ev;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_rate_r <= RUN_RATE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RUN_RATE) begin
      run_rate_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_RUN_RATE) ? {24'd0, run_rate_r} : 32'd0;

  assign consume   = in_v_r && list_free;
  assign in_tready = !in_v_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  ps2md_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .consume_i  (consume),
    .cmd_i      (in_cmd_r),
    .byte_i     (in_byte_r),
    .run_rate_i (run_rate_r),
    .ctrl_o     (ctrl),
    .list_o     (list)
  );

  ps2md_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (ctrl),
    .list_i      (list),
    .list_free_o (list_free),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_ev_o    (out_ev),
    .out_last_o  (out_tlast)
  );

  assign out_tuser = out_ev.kind;
  assign out_tdata = {5'd0,
                      out_ev.has_argument,
                      out_ev.command_argument,
                      out_ev.device_command,
                      out_ev.wheel,
                      out_ev.move_y,
                      out_ev.move_x,
                      out_ev.pressed,
                      out_ev.button_index};

endmodule
